[hw/rtl/old_password_hash_short_search_unit_macros.svh]
// assertion macros for the short password search unit
`ifndef OLD_PASSWORD_HASH_SHORT_SEARCH_UNIT_MACROS_SVH
`define OLD_PASSWORD_HASH_SHORT_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OPHSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same cycle check failed");
`define OPHSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");
`else
`define OPHSS_ASSERT_IMP(lbl, ante, cons)
`define OPHSS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/ophss_pkg.sv]
// shared constants and types for the short password search unit
package ophss_pkg;

	localparam logic [31:0] SEED_FIRST      = 32'h50305735;
	localparam logic [31:0] SEED_SECOND     = 32'h12345671;
	localparam logic [31:0] SEED_FIRST_SHL  = 32'h30573500;
	localparam logic [31:0] SEED_SECOND_SHL = 32'h34567100;
	localparam logic [7:0]  ACC_START       = 8'd7;
	localparam logic [6:0]  CODE_LOW        = 7'd33;
	localparam logic [6:0]  CODE_HIGH       = 7'd126;
	localparam logic [1:0]  LEN_NONE        = 2'd0;
	localparam logic [1:0]  LEN_ONE         = 2'd1;
	localparam logic [1:0]  LEN_TWO         = 2'd2;

	typedef struct packed {
		logic       valid;
		logic       single;
		logic       last;
		logic [6:0] c1;
		logic [6:0] c2;
	} cand_t;

	typedef struct packed {
		logic       valid;
		logic       match;
		logic       single;
		logic       last;
		logic [6:0] c1;
		logic [6:0] c2;
	} hit_t;

endpackage

[hw/rtl/old_password_hash_short_search_unit.sv]
// short password search: candidates are tried in order until one matches or the last is tried
// a request walks at most 8930 candidates, one per cycle through a six stage hash pipeline
// one request is searched at a time
// a finished result waits in the output register while the next request is searched
// asynchronous active low reset empties the pipeline, pending result and output and resets the candidate generator
`include "old_password_hash_short_search_unit_macros.svh"

module old_password_hash_short_search_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [30:0] target_first,
	input  logic [30:0] target_second,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        found,
	output logic [1:0]  pw_length,
	output logic [6:0]  first_char,
	output logic [6:0]  second_char
);

	logic        busy_q;
	logic        issuing_q;
	logic        single_q;
	logic [6:0]  c1_q, c2_q;
	logic [30:0] tgt_first_q, tgt_second_q;

	logic        pend_valid_q;
	logic        pend_found_q;
	logic [1:0]  pend_len_q;
	logic [6:0]  pend_c1_q, pend_c2_q;

	logic        rsp_valid_q;
	logic        found_q;
	logic [1:0]  len_q;
	logic [6:0]  first_q, second_q;

	logic             accept;
	logic             done;
	logic             out_load;
	logic             last_cand;
	ophss_pkg::cand_t cand;
	ophss_pkg::hit_t  hit;

	assign accept    = req_valid && !busy_q;
	assign req_stall = busy_q;
	assign last_cand = !single_q && (c1_q == ophss_pkg::CODE_HIGH)
		&& (c2_q == ophss_pkg::CODE_HIGH);
	assign cand      = '{valid: issuing_q, single: single_q, last: last_cand,
		c1: c1_q, c2: c2_q};
	assign done      = hit.valid && (hit.match || hit.last);
	assign out_load  = pend_valid_q && (!rsp_valid_q || !rsp_stall);

	ophss_hash_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.flush      (done),
		.tgt_first  (tgt_first_q),
		.tgt_second (tgt_second_q),
		.cand       (cand),
		.hit        (hit)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_first_q  <= target_first;
			tgt_second_q <= target_second;
		end
	end

	// candidate generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			single_q  <= 1'b1;
			c1_q      <= ophss_pkg::CODE_LOW;
			c2_q      <= ophss_pkg::CODE_LOW;
		end else if (accept) begin
			issuing_q <= 1'b1;
			single_q  <= 1'b1;
			c1_q      <= ophss_pkg::CODE_LOW;
			c2_q      <= ophss_pkg::CODE_LOW;
		end else if (done) begin
			issuing_q <= 1'b0;
		end else if (issuing_q) begin
			if (single_q) begin
				single_q <= 1'b0;
				c2_q     <= ophss_pkg::CODE_LOW;
			end else if (c2_q == ophss_pkg::CODE_HIGH) begin
				if (c1_q == ophss_pkg::CODE_HIGH) begin
					issuing_q <= 1'b0;
				end else begin
					c1_q     <= c1_q + 7'd1;
					single_q <= 1'b1;
				end
			end else begin
				c2_q <= c2_q + 7'd1;
			end
		end
	end

	// request tracking and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				pend_valid_q <= 1'b1;
			end else if (out_load) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			pend_found_q <= hit.match;
			pend_len_q   <= !hit.match ? ophss_pkg::LEN_NONE :
				(hit.single ? ophss_pkg::LEN_ONE : ophss_pkg::LEN_TWO);
			pend_c1_q    <= hit.match ? hit.c1 : 7'd0;
			pend_c2_q    <= (hit.match && !hit.single) ? hit.c2 : 7'd0;
		end
		if (out_load) begin
			found_q  <= pend_found_q;
			len_q    <= pend_len_q;
			first_q  <= pend_c1_q;
			second_q <= pend_c2_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign pw_length   = len_q;
	assign first_char  = first_q;
	assign second_char = second_q;

	`OPHSS_ASSERT_IMP(a_issue_in_request, issuing_q, busy_q)
	`OPHSS_ASSERT_IMP(a_no_issue_after_done, pend_valid_q, !issuing_q)
	`OPHSS_ASSERT_NXT(a_done_stops_issue, done, !issuing_q && pend_valid_q)
	`OPHSS_ASSERT_IMP(a_miss_is_zero, rsp_valid_q && !found_q,
		len_q == ophss_pkg::LEN_NONE && first_q == 7'd0 && second_q == 7'd0)
	`OPHSS_ASSERT_IMP(a_hit_shape, rsp_valid_q && found_q,
		(len_q == ophss_pkg::LEN_ONE && second_q == 7'd0) ||
		(len_q == ophss_pkg::LEN_TWO && second_q >= ophss_pkg::CODE_LOW))

endmodule

[hw/rtl/ophss_hash_pipe.sv]
// six stage hash and compare pipeline, one candidate per cycle
module ophss_hash_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	input  logic [30:0]        tgt_first,
	input  logic [30:0]        tgt_second,
	input  ophss_pkg::cand_t   cand,
	output ophss_pkg::hit_t    hit
);

	typedef struct packed {
		logic       single;
		logic       last;
		logic [6:0] c1;
		logic [6:0] c2;
	} info_t;

	logic [6:1] v_q;
	info_t info_s1, info_s2, info_s3, info_s4, info_s5, info_s6;

	logic [31:0] a1_s1, a1_s2, a1_s3;
	logic [7:0]  acc_s1;
	logic [31:0] b1_s2, b1_s3, b1_s4;
	logic [7:0]  m_s2;
	logic [14:0] p_s3;
	logic [31:0] a2_s4, a2_s5;
	logic [31:0] b2_s5;
	logic        match_s6;

	logic [7:0]  m1;
	logic [14:0] p1;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] b2_next;

	assign m1 = {2'b00, ophss_pkg::SEED_FIRST[5:0]} + ophss_pkg::ACC_START;
	assign p1 = 15'(m1) * {8'd0, cand.c1};
	assign t1 = ophss_pkg::SEED_FIRST_SHL + {17'd0, p1};
	assign t2 = {a1_s3[23:0], 8'd0} + {17'd0, p_s3};
	assign b2_next = b1_s4 + ({b1_s4[23:0], 8'd0} ^ a2_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (flush) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[5:1], cand.valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: first round on the first character
		info_s1 <= '{single: cand.single, last: cand.last, c1: cand.c1, c2: cand.c2};
		a1_s1   <= ophss_pkg::SEED_FIRST ^ t1;
		acc_s1  <= ophss_pkg::ACC_START + {1'b0, cand.c1};
		// stage 2: second word of the first round, multiplier operand
		info_s2 <= info_s1;
		a1_s2   <= a1_s1;
		b1_s2   <= ophss_pkg::SEED_SECOND + (ophss_pkg::SEED_SECOND_SHL ^ a1_s1);
		m_s2    <= {2'b00, a1_s1[5:0]} + acc_s1;
		// stage 3: second round product
		info_s3 <= info_s2;
		a1_s3   <= a1_s2;
		b1_s3   <= b1_s2;
		p_s3    <= 15'(m_s2) * {8'd0, info_s2.c2};
		// stage 4: second round first word
		info_s4 <= info_s3;
		b1_s4   <= b1_s3;
		a2_s4   <= info_s3.single ? a1_s3 : (a1_s3 ^ t2);
		// stage 5: second round second word
		info_s5 <= info_s4;
		a2_s5   <= a2_s4;
		b2_s5   <= info_s4.single ? b1_s4 : b2_next;
		// stage 6: compare with the target
		info_s6  <= info_s5;
		match_s6 <= (a2_s5[30:0] == tgt_first) && (b2_s5[30:0] == tgt_second);
	end

	assign hit = '{valid: v_q[6], match: match_s6, single: info_s6.single,
		last: info_s6.last, c1: info_s6.c1, c2: info_s6.c2};

endmodule
